// ===== rtl/kam_pkg.sv =====
// Shared types and constants of the keyed adjacency matrix.
// Holds field widths, opcode codes and the configuration reset value.
// No dependencies; every file of the block but kam_edge_rows imports it.
package kam_pkg;

    localparam int KEY_W       = 32;
    localparam int NBR_W       = 16;
    localparam int OP_W        = 2;
    localparam int CFG_W       = 5;
    localparam int MAX_RESULTS = 16;

    localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_ADD_KEY  = 2'd0;
    localparam logic [OP_W-1:0] OP_SORT     = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd2;
    localparam logic [OP_W-1:0] OP_DUMP     = 2'd3;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [NBR_W-1:0]        nbr_t;

endpackage

// ===== rtl/keyed_adjacency_matrix.sv =====
// Keyed adjacency matrix: a directed graph store with a key table and an edge bit matrix.
// Each input transaction carries an opcode; only a dump produces output transactions,
// one per active row up to MAX_RESULTS. The key table is a synchronous memory read at most
// one slot per cycle through its single read port: add key writes the next free slot, add
// edge does a linear search of both keys in one pass, a sort scans and then swaps for each
// pass i = 0 to n - 2, and a dump reads each row and then outputs it, waiting out any output
// stall, where n is the active size. The edge matrix is zero after reset through per-row
// valid flags, so no clearing pass is needed; key slots hold nothing defined until an add
// key writes them.
module keyed_adjacency_matrix #(
    parameter int MAX_NODES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,  // key_a [31:0], key_b [63:32]
    input  logic [kam_pkg::OP_W-1:0]    s_axis_tuser,  // opcode [1:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [47:0]                 m_axis_tdata,  // row_key [31:0], neighbors [47:32]
    output logic                        m_axis_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kam_pkg::CFG_W-1:0]   cfg_data
);

    import kam_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEARCH   = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_SWAP_HI  = 3'd3;
    localparam logic [2:0] ST_SWAP_LO  = 3'd4;
    localparam logic [2:0] ST_DUMP_RD  = 3'd5;
    localparam logic [2:0] ST_DUMP_OUT = 3'd6;

    key_t             key_mem [MAX_NODES];
    key_t             key_q_reg;
    logic             kr_en;
    logic [IDX_W-1:0] kr_addr;
    logic             kw_en;
    logic [IDX_W-1:0] kw_addr;
    key_t             kw_data;

    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] pass_reg, pass_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             found_a_reg, found_a_next;
    logic             found_b_reg, found_b_next;
    logic [IDX_W-1:0] idx_a_reg, idx_a_next;
    logic [IDX_W-1:0] idx_b_reg, idx_b_next;
    key_t             key_a_reg, key_a_next;
    key_t             key_b_reg, key_b_next;
    key_t             best_val_reg, best_val_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    key_t             ival_reg, ival_next;
    logic             m_valid_reg, m_valid_next;
    key_t             m_key_reg, m_key_next;
    nbr_t             m_nbr_reg, m_nbr_next;
    logic             m_last_reg, m_last_next;

    logic [CNT_W-1:0]     n_act;
    logic [CNT_W-1:0]     rows;
    logic                 issue;
    logic                 er_en;
    logic                 set_en;
    logic [MAX_NODES-1:0] edge_row;
    logic [MAX_NODES-1:0] row_mask;
    nbr_t                 nbr_view;

    kam_edge_rows #(
        .MAX_NODES (MAX_NODES)
    ) u_edge_rows (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (er_en),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .set_en  (set_en),
        .set_row (idx_a_reg),
        .set_col (idx_b_reg),
        .rd_row  (edge_row)
    );

    always_comb begin
        if (size_reg == '0) begin
            n_act = CNT_W'(1);
        end else if (int'(size_reg) > MAX_NODES) begin
            n_act = CNT_W'(MAX_NODES);
        end else begin
            n_act = CNT_W'(size_reg);
        end
        if (int'(n_act) < MAX_RESULTS) begin
            rows = n_act;
        end else begin
            rows = CNT_W'(MAX_RESULTS);
        end
        for (int k = 0; k < MAX_NODES; k++) begin
            row_mask[k] = (k < int'(n_act));
        end
        for (int k = 0; k < NBR_W; k++) begin
            if (k < MAX_NODES) begin
                nbr_view[k] = edge_row[k] & row_mask[k];
            end else begin
                nbr_view[k] = 1'b0;
            end
        end
    end

    assign issue         = (scan_reg < n_act);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_nbr_reg, m_key_reg};
    assign m_axis_tlast  = m_last_reg;

    always_comb begin
        state_next    = state_reg;
        size_next     = size_reg;
        loaded_next   = loaded_reg;
        scan_next     = scan_reg;
        pass_next     = pass_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = scan_reg[IDX_W-1:0];
        found_a_next  = found_a_reg;
        found_b_next  = found_b_reg;
        idx_a_next    = idx_a_reg;
        idx_b_next    = idx_b_reg;
        key_a_next    = key_a_reg;
        key_b_next    = key_b_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        ival_next     = ival_reg;
        m_valid_next  = m_valid_reg & ~m_axis_tready;
        m_key_next    = m_key_reg;
        m_nbr_next    = m_nbr_reg;
        m_last_next   = m_last_reg;
        kr_en         = 1'b0;
        kr_addr       = scan_reg[IDX_W-1:0];
        kw_en         = 1'b0;
        kw_addr       = loaded_reg[IDX_W-1:0];
        kw_data       = s_axis_tdata[31:0];
        er_en         = 1'b0;
        set_en        = 1'b0;

        if (cfg_valid) begin
            size_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    key_a_next   = s_axis_tdata[31:0];
                    key_b_next   = s_axis_tdata[63:32];
                    found_a_next = 1'b0;
                    found_b_next = 1'b0;
                    scan_next    = '0;
                    pass_next    = '0;
                    case (s_axis_tuser)
                        OP_ADD_KEY: begin
                            if (loaded_reg < n_act) begin
                                kw_en       = 1'b1;
                                loaded_next = loaded_reg + CNT_W'(1);
                            end
                        end
                        OP_SORT: begin
                            if (n_act > CNT_W'(1)) begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_ADD_EDGE: begin
                            state_next = ST_SEARCH;
                        end
                        default: begin
                            state_next = ST_DUMP_RD;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                kr_en        = issue;
                cmp_vld_next = issue;
                if (issue) begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                if (cmp_vld_reg) begin
                    if (!found_a_reg && key_q_reg == key_a_reg) begin
                        found_a_next = 1'b1;
                        idx_a_next   = cmp_idx_reg;
                    end
                    if (!found_b_reg && key_q_reg == key_b_reg) begin
                        found_b_next = 1'b1;
                        idx_b_next   = cmp_idx_reg;
                    end
                end
                if (!issue && !cmp_vld_reg) begin
                    set_en     = found_a_reg & found_b_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                kr_en        = issue;
                cmp_vld_next = issue;
                if (issue) begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                if (cmp_vld_reg) begin
                    if (cmp_idx_reg == pass_reg[IDX_W-1:0]) begin
                        best_val_next = key_q_reg;
                        best_idx_next = cmp_idx_reg;
                        ival_next     = key_q_reg;
                    end else if (best_val_reg > key_q_reg) begin
                        best_val_next = key_q_reg;
                        best_idx_next = cmp_idx_reg;
                    end
                end
                if (!issue && !cmp_vld_reg) begin
                    state_next = ST_SWAP_HI;
                end
            end
            ST_SWAP_HI: begin
                kw_en      = 1'b1;
                kw_addr    = best_idx_reg;
                kw_data    = ival_reg;
                state_next = ST_SWAP_LO;
            end
            ST_SWAP_LO: begin
                kw_en     = 1'b1;
                kw_addr   = pass_reg[IDX_W-1:0];
                kw_data   = best_val_reg;
                pass_next = pass_reg + CNT_W'(1);
                scan_next = pass_reg + CNT_W'(1);
                if ((CNT_W+1)'(pass_reg) + (CNT_W+1)'(2) < (CNT_W+1)'(n_act)) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_RD: begin
                if (!m_valid_reg || m_axis_tready) begin
                    kr_en      = 1'b1;
                    er_en      = 1'b1;
                    state_next = ST_DUMP_OUT;
                end
            end
            ST_DUMP_OUT: begin
                m_valid_next = 1'b1;
                m_key_next   = key_q_reg;
                m_nbr_next   = nbr_view;
                m_last_next  = (scan_reg + CNT_W'(1) == rows);
                scan_next    = scan_reg + CNT_W'(1);
                if (scan_reg + CNT_W'(1) == rows) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DUMP_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (kr_en) begin
            key_q_reg <= key_mem[kr_addr];
        end
        if (kw_en) begin
            key_mem[kw_addr] <= kw_data;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg     <= scan_next;
        pass_reg     <= pass_next;
        cmp_idx_reg  <= cmp_idx_next;
        idx_a_reg    <= idx_a_next;
        idx_b_reg    <= idx_b_next;
        key_a_reg    <= key_a_next;
        key_b_reg    <= key_b_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        ival_reg     <= ival_next;
        m_key_reg    <= m_key_next;
        m_nbr_reg    <= m_nbr_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= SIZE_RESET;
            loaded_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            found_a_reg <= 1'b0;
            found_b_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            size_reg    <= size_next;
            loaded_reg  <= loaded_next;
            cmp_vld_reg <= cmp_vld_next;
            found_a_reg <= found_a_next;
            found_b_reg <= found_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/kam_edge_rows.sv =====
// Edge matrix storage: one row of neighbor bits per slot, in a synchronous memory.
// Per-row valid flags make unwritten rows read as zero after reset.
// Depends on nothing but its parameter; instantiated by keyed_adjacency_matrix.
module kam_edge_rows #(
    parameter int MAX_NODES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    input  logic                         set_en,
    input  logic [$clog2(MAX_NODES)-1:0] set_row,
    input  logic [$clog2(MAX_NODES)-1:0] set_col,
    output logic [MAX_NODES-1:0]         rd_row
);

    localparam int IDX_W = $clog2(MAX_NODES);

    logic [MAX_NODES-1:0] row_mem [MAX_NODES];
    logic [MAX_NODES-1:0] row_vld_reg;
    logic [MAX_NODES-1:0] row_vld_next;
    logic [MAX_NODES-1:0] q_reg;
    logic                 qv_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pend_row_reg;
    logic [IDX_W-1:0]     pend_col_reg;
    logic [IDX_W-1:0]     mem_addr;
    logic                 mem_en;
    logic [MAX_NODES-1:0] row_now;
    logic [MAX_NODES-1:0] wr_row;

    // A set is a read-modify-write: the row is read now and written back next cycle.
    assign mem_addr = set_en ? set_row : rd_addr;
    assign mem_en   = set_en | rd_en;
    assign row_now  = qv_reg ? q_reg : '0;
    assign rd_row   = row_now;

    always_comb begin
        wr_row               = row_now;
        wr_row[pend_col_reg] = 1'b1;
        row_vld_next         = row_vld_reg;
        if (pend_reg) begin
            row_vld_next[pend_row_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_en) begin
            q_reg  <= row_mem[mem_addr];
            qv_reg <= row_vld_reg[mem_addr];
        end
        if (pend_reg) begin
            row_mem[pend_row_reg] <= wr_row;
        end
        pend_row_reg <= set_row;
        pend_col_reg <= set_col;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            pend_reg    <= 1'b0;
        end else begin
            row_vld_reg <= row_vld_next;
            pend_reg    <= set_en;
        end
    end

endmodule

// ===== rtl/kam_checker.sv =====
// Port-level checks for the keyed adjacency matrix, bound to its top level.
// Depends on kam_pkg for opcode codes and field widths.
module kam_port_checks (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [kam_pkg::OP_W-1:0]    s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [47:0]                 m_axis_tdata,
    input logic                        m_axis_tlast
);

    import kam_pkg::*;

    // Reset leaves no output transaction pending.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A row that is not the last of a dump means the dump is still running.
    a_dump_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input accepted in the middle of a dump");

    // Only a dump produces rows.
    a_no_spurious_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_DUMP && !m_axis_tvalid)
        |=> !m_axis_tvalid)
        else $error("row produced by an operation other than dump");

    // A stalled row holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output changed");

endmodule

bind keyed_adjacency_matrix kam_port_checks u_kam_port_checks (.*);

// ===== sim/kam_checker.sv =====
// Scoreboard for the keyed adjacency matrix: watches the input, result and size channels.
// Keeps its own key table and edge rows and compares every dump row with the prediction.
// Depends on kam_pkg for field widths, opcodes and the size reset value.
`timescale 1ns / 1ps

module kam_checker #(
    parameter int MAX_NODES = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,   // key_a [31:0], key_b [63:32]
    input  logic [kam_pkg::OP_W-1:0]  s_axis_tuser,   // opcode [1:0]
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [47:0]               m_axis_tdata,   // row_key [31:0], neighbors [47:32]
    input  logic                      m_axis_tlast,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [kam_pkg::CFG_W-1:0] cfg_data,
    output int                        mismatch_count,
    output int                        rows_pending
);

    import kam_pkg::*;

    typedef struct {
        key_t row_key;
        nbr_t nbrs;
        logic last;
    } dump_row_t;

    key_t             slot_key [MAX_NODES];
    nbr_t             adj_row  [MAX_NODES];
    int               keys_held;
    logic [CFG_W-1:0] size_reg;
    dump_row_t        dump_rows_q [$];

    function automatic int live_nodes();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_NODES) return MAX_NODES;
        return int'(size_reg);
    endfunction

    function automatic int slot_of(key_t k, int n);
        for (int i = 0; i < n; i++) begin
            if (slot_key[i] == k) return i;
        end
        return n;
    endfunction

    task automatic apply_op(logic [OP_W-1:0] op, key_t ka, key_t kb);
        int        n;
        int        a;
        int        b;
        int        best;
        int        rows;
        key_t      tmp;
        nbr_t      mask;
        dump_row_t r;
        n = live_nodes();
        case (op)
            OP_ADD_KEY: begin
                if (keys_held < n) begin
                    slot_key[keys_held] = ka;
                    keys_held++;
                end
            end
            OP_SORT: begin
                for (int i = 0; i + 1 < n; i++) begin
                    best = i;
                    for (int j = i + 1; j < n; j++) begin
                        if (slot_key[best] > slot_key[j]) best = j;
                    end
                    tmp            = slot_key[best];
                    slot_key[best] = slot_key[i];
                    slot_key[i]    = tmp;
                end
            end
            OP_ADD_EDGE: begin
                a = slot_of(ka, n);
                b = slot_of(kb, n);
                if (a < n && b < n) adj_row[a][b] = 1'b1;
            end
            default: begin
                mask = nbr_t'((1 << n) - 1);
                rows = (n < MAX_RESULTS) ? n : MAX_RESULTS;
                for (int i = 0; i < rows; i++) begin
                    r.row_key = slot_key[i];
                    r.nbrs    = adj_row[i] & mask;
                    r.last    = (i + 1 == rows);
                    dump_rows_q.push_back(r);
                end
            end
        endcase
    endtask

    task automatic note_mismatch(string what, dump_row_t want, dump_row_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected key %0d nbrs %h last %0b, got key %0d nbrs %h last %0b",
                     $time, what, want.row_key, want.nbrs, want.last,
                     got.row_key, got.nbrs, got.last);
        end
    endtask

    initial begin
        mismatch_count = 0;
        rows_pending   = 0;
    end

    always @(posedge aclk) begin
        dump_row_t got;
        dump_row_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                slot_key[i] = '0;
                adj_row[i]  = '0;
            end
            keys_held = 0;
            size_reg  = SIZE_RESET;
            dump_rows_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) size_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                apply_op(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.row_key = key_t'(m_axis_tdata[31:0]);
                got.nbrs    = m_axis_tdata[47:32];
                got.last    = m_axis_tlast;
                if (dump_rows_q.size() == 0) begin
                    want.row_key = '0;
                    want.nbrs    = '0;
                    want.last    = 1'b0;
                    note_mismatch("unexpected row", want, got);
                end else begin
                    want = dump_rows_q.pop_front();
                    if (got.row_key != want.row_key || got.nbrs != want.nbrs ||
                        got.last != want.last) begin
                        note_mismatch("row mismatch", want, got);
                    end
                end
            end
        end
        rows_pending = dump_rows_q.size();
    end

endmodule

// ===== sim/tb_keyed_adjacency_matrix.sv =====
// Testbench top for the keyed adjacency matrix: drives key, sort, edge and dump transactions
// under random idling and back-pressure, and changes the table size between phases.
// Depends on kam_pkg, the block itself and kam_checker, which does all the comparing.
`timescale 1ns / 1ps

module tb_keyed_adjacency_matrix;
    import kam_pkg::*;

    localparam int N_MAX = 16;

    logic             aclk;
    logic             aresetn;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [63:0]      s_axis_tdata;   // key_a [31:0], key_b [63:32]
    logic [OP_W-1:0]  s_axis_tuser;   // opcode [1:0]
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [47:0]      m_axis_tdata;   // row_key [31:0], neighbors [47:32]
    logic             m_axis_tlast;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    int               mismatch_count;
    int               rows_pending;

    bit               src_idle;
    bit               sink_idle;
    bit               sink_hold;
    int               keys_loaded;
    int               items_done;
    logic [CFG_W-1:0] size_now;
    key_t             known_keys [$];

    keyed_adjacency_matrix #(.MAX_NODES(N_MAX)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    kam_checker #(.MAX_NODES(N_MAX)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .rows_pending   (rows_pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("tb_keyed_adjacency_matrix NOT OK");
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                sink_hold = 1'b0;
            end else begin
                m_axis_tready <= !(sink_idle && $urandom_range(99) < 25);
            end
        end
    end

    function automatic int live_nodes(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > N_MAX) return N_MAX;
        return int'(v);
    endfunction

    function automatic key_t random_key();
        case ($urandom_range(3))
            0:       return key_t'($urandom_range(6)) - 3;
            1: begin
                case ($urandom_range(3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return -1;
                    default: return 0;
                endcase
            end
            default: return key_t'($urandom);
        endcase
    endfunction

    function automatic key_t pick_key();
        if ($urandom_range(99) < 80) return known_keys[$urandom_range(known_keys.size() - 1)];
        return random_key();
    endfunction

    task automatic send_op(logic [OP_W-1:0] op, key_t ka, key_t kb);
        @(negedge aclk);
        while (src_idle && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {kb, ka};
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic add_key(key_t k);
        send_op(OP_ADD_KEY, k, key_t'($urandom));
        if (keys_loaded < live_nodes(size_now)) begin
            known_keys.push_back(k);
            keys_loaded++;
            items_done++;
        end
    endtask

    task automatic run_op(logic [OP_W-1:0] op, key_t ka, key_t kb);
        send_op(op, ka, kb);
        items_done++;
    endtask

    task automatic drain_rows();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (rows_pending != 0) @(negedge aclk);
    endtask

    // A sort may still be running after the last dump row, so allow for its length.
    task automatic write_size(logic [CFG_W-1:0] v);
        drain_rows();
        repeat (250) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        size_now = v;
    endtask

    initial begin
        int               pick;
        int               waited;
        logic [CFG_W-1:0] next_size;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD_KEY;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        src_idle      = 1'b1;
        sink_idle     = 1'b1;
        sink_hold     = 1'b0;
        keys_loaded   = 0;
        items_done    = 0;
        size_now      = SIZE_RESET;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A single active row: table full, self loop and a missing key.
        write_size(5'd0);
        add_key(32'sh8000_0000);
        add_key(7);
        run_op(OP_DUMP, 0, 0);
        run_op(OP_ADD_EDGE, 32'sh8000_0000, 32'sh8000_0000);
        run_op(OP_ADD_EDGE, 32'sh8000_0000, 5);
        run_op(OP_SORT, 0, 0);
        run_op(OP_DUMP, 0, 0);

        // Duplicate keys resolve to the first slot; sorting leaves the rows in place.
        write_size(5'd4);
        add_key(32'sh7FFF_FFFF);
        add_key(-1);
        add_key(32'sh7FFF_FFFF);
        run_op(OP_DUMP, -1, -1);
        run_op(OP_ADD_EDGE, 32'sh7FFF_FFFF, -1);
        run_op(OP_ADD_EDGE, -1, 32'sh8000_0000);
        run_op(OP_ADD_EDGE, 0, 32'sh7FFF_FFFF);
        run_op(OP_SORT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        run_op(OP_DUMP, 0, 0);
        run_op(OP_ADD_EDGE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        run_op(OP_DUMP, 0, 0);

        for (int phase = 0; items_done < 380; phase++) begin
            case (phase)
                0:       next_size = 5'd7;
                1:       next_size = 5'd16;
                2:       next_size = 5'd31;
                3:       next_size = 5'd1;
                4:       next_size = 5'd0;
                5:       next_size = 5'd2;
                default: next_size = CFG_W'($urandom_range(31));
            endcase
            write_size(next_size);
            src_idle  = (phase != 1);
            sink_idle = (phase != 1);
            while (keys_loaded < live_nodes(size_now)) add_key(random_key());
            if (phase == 2) begin
                sink_hold = 1'b1;
                repeat (4) run_op(OP_DUMP, key_t'($urandom), key_t'($urandom));
            end
            for (int k = 0; k < 40; k++) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    add_key(random_key());
                end else if (pick < 18) begin
                    run_op(OP_SORT, key_t'($urandom), key_t'($urandom));
                end else if (pick < 78) begin
                    run_op(OP_ADD_EDGE, pick_key(), pick_key());
                end else begin
                    run_op(OP_DUMP, key_t'($urandom), key_t'($urandom));
                end
            end
        end

        drain_rows();
        waited = 0;
        while (rows_pending != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (300) @(negedge aclk);
        if (mismatch_count == 0 && rows_pending == 0) begin
            $display("tb_keyed_adjacency_matrix OK");
        end else begin
            $display("tb_keyed_adjacency_matrix NOT OK");
        end
        $finish;
    end

endmodule
